@@ rtl/ete_pkg.sv @@
// Shared types, constants and helper functions for the expiration time reader.
package ete_pkg;

  // Controller states.
  typedef enum logic [2:0] {
    CS_SCAN,
    CS_FIELDS,
    CS_LEAP,
    CS_DAYS,
    CS_SCALE,
    CS_LOAD
  } ctl_state_t;

  // Text scan phase.
  typedef enum logic [1:0] {
    SP_LEAD,
    SP_TOKEN,
    SP_DONE
  } scan_phase_t;

  // Decimal counter phase.
  typedef enum logic [1:0] {
    CP_START,
    CP_SIGN,
    CP_DIGITS,
    CP_STOP
  } cnt_phase_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic char_en;
    logic fields_en;
    logic leap_en;
    logic days_en;
    logic scale_en;
    logic load_en;
  } ete_cmd_t;

  localparam int DATE_LEN = 14;
  localparam int EPOCH_YEAR = 1970;
  localparam int CENT_BIAS = 30;
  localparam int DAYS_PER_YEAR = 365;
  localparam int SECS_PER_DAY = 86400;
  localparam int SECS_PER_HOUR = 3600;
  localparam int SECS_PER_MIN = 60;
  // Reciprocal of 100, exact for magnitudes below 43699.
  localparam int RECIP_100 = 5243;
  localparam int RECIP_SHIFT = 19;

  localparam logic [63:0] MAG_LIMIT = 64'h8000_0000_0000_0000;
  localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // Two-character field: leading decimal digits only.
  function automatic logic [6:0] field2(input logic [7:0] c0, input logic [7:0] c1);
    logic [6:0] v;
    v = 7'd0;
    if (is_digit(c0)) begin
      if (is_digit(c1)) begin
        v = 7'({3'b0, c0[3:0]}) * 7'd10 + 7'({3'b0, c1[3:0]});
      end else begin
        v = {3'b0, c0[3:0]};
      end
    end
    return v;
  endfunction

  // Four-character year field: leading decimal digits only.
  function automatic logic [13:0] field4(input logic [7:0] c0, input logic [7:0] c1,
                                         input logic [7:0] c2, input logic [7:0] c3);
    logic [13:0] v;
    logic        run;
    logic [7:0]  ch [4];
    v = 14'd0;
    run = 1'b1;
    ch[0] = c0;
    ch[1] = c1;
    ch[2] = c2;
    ch[3] = c3;
    for (int k = 0; k < 4; k++) begin
      if (run && is_digit(ch[k])) begin
        v = 14'(v * 14'd10) + 14'({10'b0, ch[k][3:0]});
      end else begin
        run = 1'b0;
      end
    end
    return v;
  endfunction

  // Days before the first of each month in a common year.
  function automatic logic [8:0] month_offset(input logic [3:0] mon);
    logic [8:0] r;
    unique case (mon)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      4'd11:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/expiration_time_text_to_epoch_top.sv @@
// Top level of the expiration time reader: controller and datapath.
//
//   channel | ports                                                   | handshake
//   --------+---------------------------------------------------------+------------------------
//   input   | in_char_code[7:0], in_end_of_text                       | in_valid / in_ready
//   result  | out_epoch_value[63:0], out_calendar_form, out_bad_month, | out_valid / out_ready
//           | out_stop_offset[7:0]                                    |
//
// Character items are taken while scanning. The item that carries end_of_text starts a
// conversion sequence of five steps (fields, leap count, days, scale, load), during which
// no item is taken; the load step waits until the result register is free.
// A result item stays in its register until taken, and scanning goes on meanwhile.
// Reset is synchronous and active low; it returns the scan state to the start of a text.
module expiration_time_text_to_epoch_top
  import ete_pkg::*;
#(
  parameter int MAX_TEXT_LENGTH = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_code,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_epoch_value,
  output logic        out_calendar_form,
  output logic        out_bad_month,
  output logic [7:0]  out_stop_offset
);

  ete_cmd_t cmd;

  // Sequencing and handshakes.
  ete_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_end_of_text (in_end_of_text),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cmd            (cmd)
  );

  // Scan, counter and conversion arithmetic.
  ete_datapath #(
    .MAX_TEXT_LENGTH (MAX_TEXT_LENGTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_char_code      (in_char_code),
    .out_epoch_value   (out_epoch_value),
    .out_calendar_form (out_calendar_form),
    .out_bad_month     (out_bad_month),
    .out_stop_offset   (out_stop_offset)
  );

endmodule

@@ rtl/ete_ctrl.sv @@
// Controller state machine: character scan, conversion sequence and result handshake.
module ete_ctrl
  import ete_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_end_of_text,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output ete_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       load_ok;

  // The result register can take a new item when empty or being drained.
  assign load_ok = !out_valid_r || out_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CS_SCAN: begin
        if (in_valid && in_end_of_text) state_nxt = CS_FIELDS;
      end
      CS_FIELDS: state_nxt = CS_LEAP;
      CS_LEAP:   state_nxt = CS_DAYS;
      CS_DAYS:   state_nxt = CS_SCALE;
      CS_SCALE:  state_nxt = CS_LOAD;
      CS_LOAD: begin
        if (load_ok) state_nxt = CS_SCAN;
      end
      default:   state_nxt = CS_SCAN;
    endcase
  end

  // Commands and handshake outputs.
  always_comb begin
    cmd           = '0;
    in_ready      = (state_r == CS_SCAN);
    cmd.char_en   = (state_r == CS_SCAN) && in_valid;
    cmd.fields_en = (state_r == CS_FIELDS);
    cmd.leap_en   = (state_r == CS_LEAP);
    cmd.days_en   = (state_r == CS_DAYS);
    cmd.scale_en  = (state_r == CS_SCALE);
    cmd.load_en   = (state_r == CS_LOAD) && load_ok;
  end

  // Result valid flag.
  always_comb begin
    if (cmd.load_en) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CS_SCAN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/ete_datapath.sv @@
// Datapath: token scan, decimal counter, staged date conversion and result register.
module ete_datapath
  import ete_pkg::*;
#(
  parameter int MAX_TEXT_LENGTH = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ete_cmd_t    cmd,
  input  logic [7:0]  in_char_code,
  output logic [63:0] out_epoch_value,
  output logic        out_calendar_form,
  output logic        out_bad_month,
  output logic [7:0]  out_stop_offset
);

  localparam int PW = $clog2(MAX_TEXT_LENGTH + 1);

  // Scan state.
  scan_phase_t phase_r, phase_nxt;
  logic [3:0]  tlen_r, tlen_nxt;
  logic [63:0] accum_r, accum_nxt;
  logic        neg_r, neg_nxt;
  cnt_phase_t  cphase_r, cphase_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] cstop_r, cstop_nxt;
  logic [7:0]  date_r [DATE_LEN];
  logic        date_we;
  logic [67:0] sum10;

  // Conversion stages.
  logic signed [15:0] years_r, yfl_r;
  logic signed [10:0] dbase_r;
  logic               bad_r;
  logic [6:0]         h_r, mi_r, s_r;
  logic signed [13:0] q4_r;
  logic [6:0]         cmag_r;
  logic               cneg_r;
  logic signed [25:0] y365_r;
  logic [19:0]        hms_r;
  logic signed [25:0] days_r;
  logic signed [43:0] prod_r;

  // Result register.
  logic [63:0] epoch_r;
  logic        calendar_r;
  logic        badm_r;
  logic [7:0]  stop_r;

  // Character scan and counter feed.
  always_comb begin
    phase_nxt  = phase_r;
    tlen_nxt   = tlen_r;
    accum_nxt  = accum_r;
    neg_nxt    = neg_r;
    cphase_nxt = cphase_r;
    pos_nxt    = pos_r;
    cstop_nxt  = cstop_r;
    date_we    = 1'b0;
    sum10      = {1'b0, accum_r, 3'b0} + {3'b0, accum_r, 1'b0}
               + {64'b0, in_char_code[3:0]};
    if (cmd.load_en) begin
      phase_nxt  = SP_LEAD;
      tlen_nxt   = 4'd0;
      accum_nxt  = 64'd0;
      neg_nxt    = 1'b0;
      cphase_nxt = CP_START;
      pos_nxt    = '0;
      cstop_nxt  = '0;
    end else if (cmd.char_en && (phase_r != SP_DONE)) begin
      if ((in_char_code == CH_NUL) || (pos_r >= PW'(MAX_TEXT_LENGTH))) begin
        if (phase_r == SP_LEAD) cstop_nxt = pos_r;
        phase_nxt = SP_DONE;
      end else if (is_space(in_char_code)) begin
        if (phase_r == SP_TOKEN) begin
          phase_nxt = SP_DONE;
        end else begin
          pos_nxt = pos_r + PW'(1);
        end
      end else begin
        if (phase_r == SP_LEAD) begin
          phase_nxt = SP_TOKEN;
          cstop_nxt = pos_r;
        end
        date_we = (tlen_r < 4'(DATE_LEN));
        if (tlen_r != 4'd15) tlen_nxt = tlen_r + 4'd1;
        // Counter: saturate the magnitude at 2^63.
        if (cphase_r != CP_STOP) begin
          if (is_digit(in_char_code)) begin
            if (sum10 > {4'b0, MAG_LIMIT}) begin
              accum_nxt = MAG_LIMIT;
            end else begin
              accum_nxt = sum10[63:0];
            end
            cphase_nxt = CP_DIGITS;
            cstop_nxt  = pos_r + PW'(1);
          end else if ((cphase_r == CP_START) &&
                       ((in_char_code == CH_PLUS) || (in_char_code == CH_MINUS))) begin
            neg_nxt    = (in_char_code == CH_MINUS);
            cphase_nxt = CP_SIGN;
          end else begin
            cphase_nxt = CP_STOP;
          end
        end
        pos_nxt = pos_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= SP_LEAD;
      tlen_r   <= 4'd0;
      accum_r  <= 64'd0;
      neg_r    <= 1'b0;
      cphase_r <= CP_START;
      pos_r    <= '0;
      cstop_r  <= '0;
    end else begin
      phase_r  <= phase_nxt;
      tlen_r   <= tlen_nxt;
      accum_r  <= accum_nxt;
      neg_r    <= neg_nxt;
      cphase_r <= cphase_nxt;
      pos_r    <= pos_nxt;
      cstop_r  <= cstop_nxt;
    end
  end

  // First fourteen token characters.
  always_ff @(posedge clk) begin
    if (date_we) date_r[tlen_r] <= in_char_code;
  end

  // Stage one: split the date into fields.
  logic [13:0] f_year;
  logic [6:0]  f_mon, f_day;
  logic [3:0]  f_mon0;
  logic        f_before;
  logic signed [15:0] f_years;

  always_comb begin
    f_year   = field4(date_r[0], date_r[1], date_r[2], date_r[3]);
    f_mon    = field2(date_r[4], date_r[5]);
    f_day    = field2(date_r[6], date_r[7]);
    f_mon0   = 4'(f_mon - 7'd1);
    f_before = (f_mon0 == 4'd0) || ((f_mon0 == 4'd1) && (f_day <= 7'd29));
    f_years  = $signed({2'b0, f_year}) - 16'(EPOCH_YEAR);
  end

  always_ff @(posedge clk) begin
    if (cmd.fields_en) begin
      years_r <= f_years;
      yfl_r   <= f_before ? f_years - 16'sd1 : f_years;
      dbase_r <= $signed({2'b0, month_offset(f_mon0)}) + $signed({4'b0, f_day}) - 11'sd1;
      bad_r   <= (f_mon < 7'd1) || (f_mon > 7'd12);
      h_r     <= field2(date_r[8], date_r[9]);
      mi_r    <= field2(date_r[10], date_r[11]);
      s_r     <= field2(date_r[12], date_r[13]);
    end
  end

  // Stage two: quarter and century quotients, year days, time of day.
  logic signed [15:0] l_v, l_x;
  logic [15:0]        l_vm, l_xm;
  logic [13:0]        l_qm;
  logic [28:0]        l_cp;

  always_comb begin
    l_v  = yfl_r + 16'sd2;
    l_vm = l_v[15] ? 16'(-l_v) : 16'(l_v);
    l_qm = 14'(l_vm >> 2);
    l_x  = yfl_r - 16'(CENT_BIAS);
    l_xm = l_x[15] ? 16'(-l_x) : 16'(l_x);
    l_cp = 29'(l_xm) * 29'(RECIP_100);
  end

  always_ff @(posedge clk) begin
    if (cmd.leap_en) begin
      q4_r   <= l_v[15] ? -$signed(l_qm) : $signed(l_qm);
      cmag_r <= l_cp[RECIP_SHIFT+6:RECIP_SHIFT];
      cneg_r <= l_x[15];
      y365_r <= 26'(years_r) * 26'sd365;
      hms_r  <= 20'(h_r) * 20'(SECS_PER_HOUR) + 20'(mi_r) * 20'(SECS_PER_MIN) + 20'(s_r);
    end
  end

  // Stage three: day count since the epoch.
  logic [6:0]         d_corr;
  logic signed [15:0] d_corr_s, d_leaps;

  always_comb begin
    d_corr   = 7'(cmag_r[6:2]) * 7'd3 + 7'(cmag_r[1:0]);
    d_corr_s = $signed({9'b0, d_corr});
    d_leaps  = 16'(q4_r) + (cneg_r ? d_corr_s : -d_corr_s);
  end

  always_ff @(posedge clk) begin
    if (cmd.days_en) begin
      days_r <= 26'(dbase_r) + y365_r + 26'(d_leaps);
    end
  end

  // Stage four: days to seconds.
  always_ff @(posedge clk) begin
    if (cmd.scale_en) begin
      prod_r <= 44'(days_r) * 44'(SECS_PER_DAY);
    end
  end

  // Result selection.
  logic        r_cal;
  logic [63:0] r_cnt, r_date;

  always_comb begin
    r_cal  = (tlen_r == 4'(DATE_LEN));
    r_date = bad_r ? 64'd0 : {{20{prod_r[43]}}, prod_r} + {44'b0, hms_r};
    if (neg_r) begin
      r_cnt = 64'd0 - accum_r;
    end else begin
      r_cnt = accum_r[63] ? POS_LIMIT : accum_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_en) begin
      epoch_r    <= r_cal ? r_date : r_cnt;
      calendar_r <= r_cal;
      badm_r     <= r_cal && bad_r;
      if (r_cal || (phase_r == SP_LEAD)) begin
        stop_r <= 8'(pos_r);
      end else begin
        stop_r <= 8'(cstop_r);
      end
    end
  end

  assign out_epoch_value   = epoch_r;
  assign out_calendar_form = calendar_r;
  assign out_bad_month     = badm_r;
  assign out_stop_offset   = stop_r;

endmodule
